// ===== src/bfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants of the shortest-path engine.
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int ID_W          = 6;
    localparam int IN_WEIGHT_W   = 16;
    localparam int COST_W        = 32;
    localparam int CFG_VCOUNT_W  = 7;
    localparam int CFG_SOURCE_W  = 6;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;
    localparam int DEF_WEIGHT_BITS  = 16;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_SOURCE       = 1'b1;

    localparam logic signed [COST_W-1:0] COST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COST_W-1:0] COST_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                          carries_edge;
        logic [ID_W-1:0]               from_vertex;
        logic [ID_W-1:0]               to_vertex;
        logic signed [IN_WEIGHT_W-1:0] edge_weight;
        logic                          final_item;
    } t_in_req;

    typedef struct packed {
        logic [ID_W-1:0]          vertex_index;
        logic signed [COST_W-1:0] path_cost;
        logic                     reached;
        logic                     no_negative_cycle;
        logic                     edges_dropped;
        logic                     last_result;
    } t_out_res;

    typedef struct packed {
        logic                     ok;
        logic signed [COST_W-1:0] cost;
    } t_dist_entry;

    typedef struct packed {
        logic [CFG_VCOUNT_W-1:0] vertex_count;
        logic [CFG_SOURCE_W-1:0] source_vertex;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_VRD,
        ST_VCMP,
        ST_PEND,
        ST_ERD,
        ST_ELD,
        ST_EOUT
    } t_state;

endpackage

// ===== src/bfsp_apb_regs.sv =====
// ----------------------------------------------------------------------------
// bfsp_apb_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module bfsp_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfsp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bfsp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bfsp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output bfsp_pkg::t_cfg                      o_cfg
);

    bfsp_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vertex_count  <= bfsp_pkg::CFG_VCOUNT_W'(1);
            r_cfg.source_vertex <= '0;
        end else if (w_wr) begin
            unique case (paddr[2])
                bfsp_pkg::REG_VERTEX_COUNT: begin
                    r_cfg.vertex_count <= pwdata[bfsp_pkg::CFG_VCOUNT_W-1:0];
                end
                bfsp_pkg::REG_SOURCE: begin
                    r_cfg.source_vertex <= pwdata[bfsp_pkg::CFG_SOURCE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            bfsp_pkg::REG_VERTEX_COUNT: prdata = bfsp_pkg::APB_DATA_W'(r_cfg.vertex_count);
            bfsp_pkg::REG_SOURCE:       prdata = bfsp_pkg::APB_DATA_W'(r_cfg.source_vertex);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== src/bfsp_edge_mem.sv =====
// ----------------------------------------------------------------------------
// bfsp_edge_mem
// Edge store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfsp_edge_mem #(
    parameter int DEPTH  = bfsp_pkg::DEF_MAX_EDGES,
    parameter int AW     = 8,
    parameter int DW     = 28
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/bfsp_dist_mem.sv =====
// ----------------------------------------------------------------------------
// bfsp_dist_mem
// Distance store: cost and reached bit per vertex, registered read.
// ----------------------------------------------------------------------------
module bfsp_dist_mem #(
    parameter int DEPTH = bfsp_pkg::DEF_MAX_VERTICES,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  bfsp_pkg::t_dist_entry i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output bfsp_pkg::t_dist_entry o_rdata
);

    bfsp_pkg::t_dist_entry r_mem [DEPTH];
    bfsp_pkg::t_dist_entry r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/bellman_ford_shortest_path_top.sv =====
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_top
// Single-source shortest paths over a loaded edge list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req) carries one edge per
//   request; a request with final_item set closes the load and starts the
//   solve. Edge requests are accepted only while the block is idle.
//   The solve clears the distance store, then runs passes; for each vertex a
//   pass scans every stored edge through the edge store and distance store
//   read ports, then compares and updates that vertex's distance. It runs at
//   most vertex_count-1 passes plus one check pass.
//   Output channel (o_out_valid / i_out_stall / o_out_res) then delivers one
//   result per vertex in ascending order; each result is read from the
//   distance store only after the previous one is taken. A final request with
//   vertex_count zero returns no results and the block stays idle.
//   Otherwise o_in_stall stays high from the final request until the last
//   result is taken. A stalled result holds its payload until taken.
//   Reset clears the edge count, drop flag, state and output valid; the
//   registers return to vertex_count 1, source_vertex 0.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_top #(
    parameter int MAX_VERTICES = bfsp_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = bfsp_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = bfsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bfsp_pkg::t_in_req               i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bfsp_pkg::t_out_res              o_out_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfsp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bfsp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bfsp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int IDW = bfsp_pkg::ID_W;
    localparam int EDW = 2 * IDW + WEIGHT_BITS;
    localparam int CPW = bfsp_pkg::CFG_VCOUNT_W;

    bfsp_pkg::t_cfg w_cfg;

    bfsp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bfsp_pkg::t_state      r_state, n_state;
    logic [ECW-1:0]        r_fill, n_fill;
    logic                  r_drop, n_drop;
    logic [CW-1:0]         r_v, n_v;
    logic [ECW-1:0]        r_k, n_k;
    logic                  r_s1_v, n_s1_v;
    logic                  r_s2_v, n_s2_v;
    logic [WEIGHT_BITS-1:0] r_w2, n_w2;
    logic                  r_have, n_have;
    logic signed [31:0]    r_best, n_best;
    logic                  r_changed, n_changed;
    logic                  r_check, n_check;
    logic [CW-1:0]         r_pass, n_pass;
    logic                  r_nonneg, n_nonneg;
    logic                  r_out_valid, n_out_valid;
    bfsp_pkg::t_out_res    r_out, n_out;

    logic [CW-1:0]         w_n;
    logic [CW-1:0]         w_last_v;
    logic                  w_in_acc;
    logic                  w_drop;
    logic                  w_e_we;
    logic [EDW-1:0]        w_e_wdata;
    logic [EDW-1:0]        w_e_rdata;
    logic [IDW-1:0]        w_e_from;
    logic [IDW-1:0]        w_e_to;
    logic [WEIGHT_BITS-1:0] w_e_w;
    logic [31:0]           w_w32;
    logic                  w_d_we;
    logic [VW-1:0]         w_d_waddr;
    bfsp_pkg::t_dist_entry w_d_wdata;
    logic [VW-1:0]         w_d_raddr;
    bfsp_pkg::t_dist_entry w_d_rdata;
    logic signed [32:0]    w_sum;
    logic signed [31:0]    w_sat;

    assign w_n = (w_cfg.vertex_count > CPW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                           : w_cfg.vertex_count[CW-1:0];
    assign w_last_v   = w_n - CW'(1);
    assign o_in_stall = (r_state != bfsp_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_w32      = {16'b0, i_in_req.edge_weight};
    assign w_drop     = (r_fill >= ECW'(MAX_EDGES))
                     || (CPW'(i_in_req.from_vertex) >= CPW'(w_n))
                     || (CPW'(i_in_req.to_vertex) >= CPW'(w_n));
    assign w_e_we     = w_in_acc && i_in_req.carries_edge && !w_drop;
    assign w_e_wdata  = {i_in_req.from_vertex, i_in_req.to_vertex, w_w32[WEIGHT_BITS-1:0]};
    assign w_e_from   = w_e_rdata[EDW-1 -: IDW];
    assign w_e_to     = w_e_rdata[WEIGHT_BITS +: IDW];
    assign w_e_w      = w_e_rdata[WEIGHT_BITS-1:0];

    bfsp_edge_mem #(
        .DEPTH (MAX_EDGES),
        .AW    (EAW),
        .DW    (EDW)
    ) u_edges (
        .i_clk   (i_clk),
        .i_we    (w_e_we),
        .i_waddr (r_fill[EAW-1:0]),
        .i_wdata (w_e_wdata),
        .i_raddr (r_k[EAW-1:0]),
        .o_rdata (w_e_rdata)
    );

    bfsp_dist_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_raddr (w_d_raddr),
        .o_rdata (w_d_rdata)
    );

    assign w_sum = {w_d_rdata.cost[31], w_d_rdata.cost}
                 + {{(33 - WEIGHT_BITS){r_w2[WEIGHT_BITS-1]}}, r_w2};
    always_comb begin
        if (w_sum[32] != w_sum[31]) begin
            w_sat = w_sum[32] ? bfsp_pkg::COST_MIN : bfsp_pkg::COST_MAX;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfsp_pkg::ST_IDLE;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_v         <= '0;
            r_k         <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_have      <= 1'b0;
            r_changed   <= 1'b0;
            r_check     <= 1'b0;
            r_pass      <= '0;
            r_nonneg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_drop      <= n_drop;
            r_v         <= n_v;
            r_k         <= n_k;
            r_s1_v      <= n_s1_v;
            r_s2_v      <= n_s2_v;
            r_have      <= n_have;
            r_changed   <= n_changed;
            r_check     <= n_check;
            r_pass      <= n_pass;
            r_nonneg    <= n_nonneg;
            r_out_valid <= n_out_valid;
        end
        r_w2   <= n_w2;
        r_best <= n_best;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_drop      = r_drop;
        n_v         = r_v;
        n_k         = r_k;
        n_s1_v      = 1'b0;
        n_s2_v      = r_s1_v && (CPW'(w_e_to) == CPW'(r_v))
                   && (CPW'(w_e_from) < CPW'(w_n));
        n_w2        = w_e_w;
        n_have      = r_have;
        n_best      = r_best;
        n_changed   = r_changed;
        n_check     = r_check;
        n_pass      = r_pass;
        n_nonneg    = r_nonneg;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_d_we      = 1'b0;
        w_d_waddr   = r_v[VW-1:0];
        w_d_wdata   = '{ok: 1'b1, cost: r_best};
        w_d_raddr   = w_e_from[VW-1:0];

        if (r_s2_v && w_d_rdata.ok && (!r_have || (w_sat < r_best))) begin
            n_best = w_sat;
            n_have = 1'b1;
        end

        unique case (r_state)
            bfsp_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_e_we) begin
                        n_fill = r_fill + ECW'(1);
                    end
                    if (i_in_req.carries_edge && w_drop) begin
                        n_drop = 1'b1;
                    end
                    if (i_in_req.final_item) begin
                        if (w_n == '0) begin
                            n_fill = '0;
                            n_drop = 1'b0;
                        end else begin
                            n_v     = '0;
                            n_state = bfsp_pkg::ST_INIT;
                        end
                    end
                end
            end
            bfsp_pkg::ST_INIT: begin
                w_d_we    = 1'b1;
                w_d_wdata = '{ok: (CPW'(w_cfg.source_vertex) == CPW'(r_v)), cost: '0};
                if (r_v == w_last_v) begin
                    n_v       = '0;
                    n_k       = '0;
                    n_have    = 1'b0;
                    n_check   = (w_n == CW'(1));
                    n_pass    = '0;
                    n_changed = 1'b0;
                    n_state   = bfsp_pkg::ST_SCAN;
                end else begin
                    n_v = r_v + CW'(1);
                end
            end
            bfsp_pkg::ST_SCAN: begin
                if (r_k < r_fill) begin
                    n_s1_v = 1'b1;
                    n_k    = r_k + ECW'(1);
                end else begin
                    n_state = bfsp_pkg::ST_DRAIN;
                end
            end
            bfsp_pkg::ST_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_state = bfsp_pkg::ST_VRD;
                end
            end
            bfsp_pkg::ST_VRD: begin
                w_d_raddr = r_v[VW-1:0];
                n_state   = bfsp_pkg::ST_VCMP;
            end
            bfsp_pkg::ST_VCMP: begin
                if (r_have && (!w_d_rdata.ok || (r_best < w_d_rdata.cost))) begin
                    w_d_we    = 1'b1;
                    n_changed = 1'b1;
                end
                n_k    = '0;
                n_have = 1'b0;
                if (r_v == w_last_v) begin
                    n_state = bfsp_pkg::ST_PEND;
                end else begin
                    n_v     = r_v + CW'(1);
                    n_state = bfsp_pkg::ST_SCAN;
                end
            end
            bfsp_pkg::ST_PEND: begin
                n_v = '0;
                if (r_check) begin
                    n_nonneg = !r_changed;
                    n_state  = bfsp_pkg::ST_ERD;
                end else if (!r_changed) begin
                    n_nonneg = 1'b1;
                    n_state  = bfsp_pkg::ST_ERD;
                end else begin
                    n_pass    = r_pass + CW'(1);
                    n_changed = 1'b0;
                    n_k       = '0;
                    n_have    = 1'b0;
                    if (r_pass + CW'(1) == w_last_v) begin
                        n_check = 1'b1;
                    end
                    n_state = bfsp_pkg::ST_SCAN;
                end
            end
            bfsp_pkg::ST_ERD: begin
                w_d_raddr = r_v[VW-1:0];
                n_state   = bfsp_pkg::ST_ELD;
            end
            bfsp_pkg::ST_ELD: begin
                n_out.vertex_index      = IDW'(r_v);
                n_out.path_cost         = w_d_rdata.ok ? w_d_rdata.cost : bfsp_pkg::COST_MAX;
                n_out.reached           = w_d_rdata.ok;
                n_out.no_negative_cycle = r_nonneg;
                n_out.edges_dropped     = r_drop;
                n_out.last_result       = (r_v == w_last_v);
                n_out_valid             = 1'b1;
                n_state                 = bfsp_pkg::ST_EOUT;
            end
            bfsp_pkg::ST_EOUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_v == w_last_v) begin
                        n_fill  = '0;
                        n_drop  = 1'b0;
                        n_state = bfsp_pkg::ST_IDLE;
                    end else begin
                        n_v     = r_v + CW'(1);
                        n_state = bfsp_pkg::ST_ERD;
                    end
                end
            end
            default: begin
                n_state = bfsp_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= ECW'(MAX_EDGES))
        else $error("edge count past capacity");

    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == bfsp_pkg::ST_EOUT))
        else $error("result valid outside output state");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_res.last_result)
        |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after last result");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfsp_pkg::ST_SCAN) |-> (r_k <= r_fill))
        else $error("edge scan past fill");

endmodule
